// File: rtl/ial_pkg.sv
// Shared types and constants of the indexed array list core.
package ial_pkg;

    localparam int IAL_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int CNT_OUT_W    = 5;
    localparam int STATUS_W     = 2;
    localparam int MODE_W       = 3;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 40;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_POP_BACK   = 3'd1,
        MODE_PUSH_FRONT = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_INSERT     = 3'd4,
        MODE_DELETE     = 3'd5,
        MODE_DUMP       = 3'd6
    } mode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic op_en;      // perform the list operation of the accepted word
        logic dump_start; // clear the dump index
        logic rotate;     // rotate the list by one during a dump
        logic dumping;    // output shows the front element
    } ial_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic dump_last;
    } ial_stat_t;

endpackage

// File: rtl/ial_ctrl.sv
// Controller state machine of the indexed array list core.
module ial_ctrl
    import ial_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  mode_t     in_mode,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ial_cmd_t  cmd,
    input  ial_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_OUT  = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == MODE_DUMP && !stat.cnt_zero)
                    begin
                        cmd.dump_start = 1'b1;
                        state_next     = S_DUMP;
                    end
                    else
                    begin
                        cmd.op_en  = 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                out_valid   = 1'b1;
                cmd.dumping = 1'b1;
                if (out_ready)
                begin
                    cmd.rotate = 1'b1;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/ial_dpath.sv
// Datapath of the indexed array list core: shifting element chain, count, result.
module ial_dpath
    import ial_pkg::*;
#(
    parameter int CAPACITY = IAL_CAPACITY
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ial_cmd_t             cmd,
    output ial_stat_t            stat,
    input  mode_t                in_mode,
    input  logic [DATA_W-1:0]    in_value,
    input  logic [POS_W-1:0]     in_position,
    output logic [STATUS_W-1:0]  out_status,
    output logic [CNT_OUT_W-1:0] out_count,
    output logic [DATA_W-1:0]    out_data,
    output logic                 out_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_W-1:0] cell_reg [CAPACITY];
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     idx_reg, idx_next;
    status_t           status_reg;

    logic [WW-1:0] cnt_w, cnt_m1, pos_w, sel_pos;
    logic          is_put, is_take;
    status_t       st;
    logic          do_put, do_take;

    assign cnt_w  = WW'(cnt_reg);
    assign cnt_m1 = cnt_w - WW'(1);
    assign pos_w  = WW'(in_position);

    // decode the operation and check it
    always_comb
    begin
        is_put  = 1'b0;
        is_take = 1'b0;
        sel_pos = '0;
        st      = ST_OK;
        case (in_mode)
            MODE_PUSH_BACK:
            begin
                is_put  = 1'b1;
                sel_pos = cnt_w;
            end
            MODE_POP_BACK:
            begin
                is_take = 1'b1;
                sel_pos = cnt_m1;
            end
            MODE_PUSH_FRONT: is_put  = 1'b1;
            MODE_POP_FRONT:  is_take = 1'b1;
            MODE_INSERT:
            begin
                is_put  = 1'b1;
                sel_pos = pos_w;
            end
            MODE_DELETE:
            begin
                is_take = 1'b1;
                sel_pos = pos_w;
            end
            MODE_DUMP:       st = ST_EMPTY; // only an empty dump comes here
            default:         st = ST_OK;
        endcase
        if (is_put)
        begin
            if (sel_pos > cnt_w)
                st = ST_RANGE;
            else if (cnt_w >= WW'(CAPACITY))
                st = ST_FULL;
        end
        if (is_take)
        begin
            if (cnt_reg == '0)
                st = ST_EMPTY;
            else if (sel_pos >= cnt_w)
                st = ST_RANGE;
        end
    end

    assign do_put  = cmd.op_en && is_put  && (st == ST_OK);
    assign do_take = cmd.op_en && is_take && (st == ST_OK);

    // element chain: every cell shifts at once
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int PREV = (i > 0) ? i - 1 : 0;
        localparam int NEXT = (i < CAPACITY - 1) ? i + 1 : i;
        localparam logic [WW-1:0] IDX = WW'(i);
        logic [DATA_W-1:0] cell_next;

        always_comb
        begin
            cell_next = cell_reg[i];
            if (do_put)
            begin
                if (IDX == sel_pos)
                    cell_next = in_value;
                else if (IDX > sel_pos)
                    cell_next = cell_reg[PREV];
            end
            else if (do_take)
            begin
                if (IDX >= sel_pos && i < CAPACITY - 1)
                    cell_next = cell_reg[NEXT];
            end
            else if (cmd.rotate)
            begin
                if (IDX == cnt_m1)
                    cell_next = cell_reg[0];
                else if (IDX < cnt_m1)
                    cell_next = cell_reg[NEXT];
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[i] <= cell_next;
        end
    end

    // element count and dump index
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_put)
            cnt_next = cnt_reg + CW'(1);
        else if (do_take)
            cnt_next = cnt_reg - CW'(1);
        idx_next = idx_reg;
        if (cmd.dump_start)
            idx_next = '0;
        else if (cmd.rotate)
            idx_next = idx_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // result status
    always_ff @(posedge clk)
    begin
        if (cmd.op_en)
            status_reg <= st;
    end

    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.dump_last = (WW'(idx_reg) == cnt_m1);

    // output word
    assign out_count  = cnt_w[CNT_OUT_W-1:0];
    assign out_status = cmd.dumping ? ST_OK : status_reg;
    assign out_data   = cmd.dumping ? cell_reg[0] : '0;
    assign out_last   = cmd.dumping ? stat.dump_last : 1'b1;

endmodule

// File: rtl/indexed_array_list_core.sv
// A non-dump word, or a dump of an empty list, gives its one result word in the cycle after acceptance;
// a new word is taken only once that result or dump has been taken. A non-empty dump
// gives count words, one a cycle while m_tready holds, the list rotating once through its register chain.
// Reset (rst_n, asynchronous, active low) empties the list and returns to idle;
// element storage is not cleared.
module indexed_array_list_core
    import ial_pkg::*;
#(
    parameter int CAPACITY = IAL_CAPACITY
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // mode[2:0], value[34:3], position[39:35]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // status[1:0], count[6:2], data[38:7], zero[39]
    output logic                 m_tlast
);

    ial_cmd_t             cmd;
    ial_stat_t            stat;
    mode_t                mode;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] count;
    logic [DATA_W-1:0]    data;

    assign mode = mode_t'(s_tdata[MODE_W-1:0]);

    ial_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_mode   (mode),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ial_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_mode     (mode),
        .in_value    (s_tdata[MODE_W +: DATA_W]),
        .in_position (s_tdata[MODE_W + DATA_W +: POS_W]),
        .out_status  (status),
        .out_count   (count),
        .out_data    (data),
        .out_last    (m_tlast)
    );

    // pack the result word
    assign m_tdata = {1'b0, data, count, status};

endmodule
